@@ hw/rtl/nn_layer_walk_sequencer_top_assert.svh @@
// Assertion macros for the layer walk sequencer checker.
// Needs a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef NN_LAYER_WALK_SEQUENCER_TOP_ASSERT_SVH
`define NN_LAYER_WALK_SEQUENCER_TOP_ASSERT_SVH

// same-cycle implication
`define NLWS_CHK_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define NLWS_CHK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/nlws_pkg.sv @@
// Shared types, widths and codes of the layer walk sequencer.
// No dependencies.
package nlws_pkg;

    localparam int MAX_LAYERS = 16;
    localparam int LIDX_W     = $clog2(MAX_LAYERS);
    localparam int LCNT_W     = LIDX_W + 1;
    localparam int DIM_W      = 8;
    localparam int WIN_W      = 4;
    localparam int BUD_W      = 16;
    localparam int POS_W      = 24;
    localparam int PROD_W     = 2 * DIM_W;
    localparam int BAND_W     = PROD_W + WIN_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 22;
    localparam int ACC_CAP_W  = 22;

    typedef enum logic [1:0] {
        OP_LOAD    = 2'd0,
        OP_BEGIN   = 2'd1,
        OP_STEP    = 2'd2,
        OP_ABANDON = 2'd3
    } t_op;

    localparam logic [1:0] KIND_CONV  = 2'd0;
    localparam logic [1:0] KIND_POOL  = 2'd1;
    localparam logic [1:0] KIND_DENSE = 2'd2;
    localparam logic [1:0] KIND_RSVD  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_LAYER_COUNT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DATAFLOW_MODE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ALIGN_LOG2    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ACC_CAPACITY  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FINAL_BUFFER  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_LENGTH = 3'd5;

    typedef struct packed {
        logic [1:0]       kind;
        logic [DIM_W-1:0] ih;
        logic [DIM_W-1:0] iw;
        logic [DIM_W-1:0] ic;
        logic [DIM_W-1:0] oh;
        logic [DIM_W-1:0] ow;
        logic [DIM_W-1:0] oc;
        logic [WIN_W-1:0] k;
        logic [1:0]       bufs;
    } t_desc;

    typedef struct packed {
        logic              take;
        logic              scan_en;
        logic [LIDX_W-1:0] scan_idx;
        logic              begin_apply;
        logic              prod;
        logic              hdr_status;
        logic              chunk;
        logic              div1_go;
        logic              div2_go;
        logic              row;
        logic              fin1;
        logic              fin2;
    } t_ctl_cmd;

    typedef struct packed {
        logic              fin;
        logic              budget_zero;
        logic              div_busy;
        logic [LCNT_W-1:0] cnt;
    } t_dp_sts;

    typedef struct packed {
        logic [LIDX_W-1:0] layer_index;
        logic [1:0]        kernel_kind;
        logic [POS_W-1:0]  first_unit;
        logic [POS_W-1:0]  unit_count;
        logic [1:0]        buffer_sel;
        logic              finished;
        logic [POS_W-1:0]  live_in_offset;
        logic [POS_W-1:0]  live_in_length;
        logic [POS_W-1:0]  live_out_length;
        logic [POS_W-1:0]  live_acc_bytes;
        logic              status;
    } t_res;

    // rows of accumulator band kept per layer
    function automatic logic [WIN_W-1:0] band_rows(input logic [1:0] kind,
                                                   input logic ds,
                                                   input logic [WIN_W-1:0] k);
        logic [WIN_W-1:0] r;
        r = '0;
        if (!ds) begin
            if (kind == KIND_CONV) begin
                r = k;
            end else if (kind == KIND_POOL) begin
                r = WIN_W'(1);
            end
        end
        return r;
    endfunction

endpackage

@@ hw/rtl/nlws_cmd_if.sv @@
// Command channel interface of the layer walk sequencer.
// Depends on nlws_pkg.
interface nlws_cmd_if;
    logic                         valid;
    logic                         ready;
    logic [1:0]                   opcode;
    logic [nlws_pkg::LIDX_W-1:0]  layer_slot;
    logic [1:0]                   layer_kind;
    logic [nlws_pkg::DIM_W-1:0]   in_height;
    logic [nlws_pkg::DIM_W-1:0]   in_width;
    logic [nlws_pkg::DIM_W-1:0]   in_channels;
    logic [nlws_pkg::DIM_W-1:0]   out_height;
    logic [nlws_pkg::DIM_W-1:0]   out_width;
    logic [nlws_pkg::DIM_W-1:0]   out_channels;
    logic [nlws_pkg::WIN_W-1:0]   window_size;
    logic [1:0]                   buffer_pair;
    logic [nlws_pkg::BUD_W-1:0]   unit_budget;

    modport source (output valid, opcode, layer_slot, layer_kind, in_height, in_width,
                    in_channels, out_height, out_width, out_channels, window_size,
                    buffer_pair, unit_budget, input ready);
    modport sink (input valid, opcode, layer_slot, layer_kind, in_height, in_width,
                  in_channels, out_height, out_width, out_channels, window_size,
                  buffer_pair, unit_budget, output ready);
endinterface

@@ hw/rtl/nlws_res_if.sv @@
// Result channel interface of the layer walk sequencer.
// Depends on nlws_pkg.
interface nlws_res_if;
    logic                         valid;
    logic                         ready;
    logic [nlws_pkg::LIDX_W-1:0]  layer_index;
    logic [1:0]                   kernel_kind;
    logic [nlws_pkg::POS_W-1:0]   first_unit;
    logic [nlws_pkg::POS_W-1:0]   unit_count;
    logic [1:0]                   buffer_sel;
    logic                         finished;
    logic [nlws_pkg::POS_W-1:0]   live_in_offset;
    logic [nlws_pkg::POS_W-1:0]   live_in_length;
    logic [nlws_pkg::POS_W-1:0]   live_out_length;
    logic [nlws_pkg::POS_W-1:0]   live_acc_bytes;
    logic                         status;
    logic                         last;

    modport source (output valid, layer_index, kernel_kind, first_unit, unit_count,
                    buffer_sel, finished, live_in_offset, live_in_length,
                    live_out_length, live_acc_bytes, status, last, input ready);
    modport sink (input valid, layer_index, kernel_kind, first_unit, unit_count,
                  buffer_sel, finished, live_in_offset, live_in_length,
                  live_out_length, live_acc_bytes, status, last, output ready);
endinterface

@@ hw/rtl/nlws_div.sv @@
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on nlws_pkg. Divide by zero gives 0 at once.
module nlws_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [nlws_pkg::POS_W-1:0]    i_dividend,
    input  logic [nlws_pkg::PROD_W-1:0]   i_divisor,
    output logic                          o_busy,
    output logic [nlws_pkg::POS_W-1:0]    o_quot
);
    localparam int CNT_W = $clog2(nlws_pkg::POS_W + 1);

    logic                          r_busy;
    logic [CNT_W-1:0]              r_cnt;
    logic [nlws_pkg::PROD_W-1:0]   r_rem;
    logic [nlws_pkg::PROD_W-1:0]   r_dvs;
    logic [nlws_pkg::POS_W-1:0]    r_q;
    logic [nlws_pkg::PROD_W:0]     rem_sh;
    logic [nlws_pkg::PROD_W+1:0]   trial;

    assign rem_sh = {r_rem, r_q[nlws_pkg::POS_W-1]};
    assign trial  = {1'b0, rem_sh} - {2'b00, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= (i_divisor != '0);
            r_cnt  <= CNT_W'(nlws_pkg::POS_W);
        end else if (r_busy) begin
            r_cnt  <= r_cnt - CNT_W'(1);
            r_busy <= (r_cnt != CNT_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvs <= i_divisor;
            r_q   <= (i_divisor != '0) ? i_dividend : '0;
        end else if (r_busy) begin
            if (!trial[nlws_pkg::PROD_W+1]) begin
                r_rem <= trial[nlws_pkg::PROD_W-1:0];
                r_q   <= {r_q[nlws_pkg::POS_W-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh[nlws_pkg::PROD_W-1:0];
                r_q   <= {r_q[nlws_pkg::POS_W-2:0], 1'b0};
            end
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_q;
endmodule

@@ hw/rtl/nlws_datapath.sv @@
// Datapath: descriptor table, walk position, config registers, live region math.
// Depends on nlws_pkg and nlws_div.
module nlws_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  nlws_pkg::t_ctl_cmd                i_cmd,
    output nlws_pkg::t_dp_sts                 o_sts,
    input  logic [1:0]                        i_opcode,
    input  nlws_pkg::t_desc                   i_desc,
    input  logic [nlws_pkg::LIDX_W-1:0]       i_slot,
    input  logic [nlws_pkg::BUD_W-1:0]        i_budget,
    input  logic                              i_cfg_we,
    input  logic [nlws_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [nlws_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output nlws_pkg::t_res                    o_res
);
    localparam int LI = nlws_pkg::LIDX_W;
    localparam int LC = nlws_pkg::LCNT_W;
    localparam int PW = nlws_pkg::POS_W;
    localparam int QW = nlws_pkg::PROD_W;
    localparam int BW = nlws_pkg::BAND_W;
    localparam int DW = nlws_pkg::DIM_W;
    localparam int KW = nlws_pkg::WIN_W;

    nlws_pkg::t_desc r_tbl [nlws_pkg::MAX_LAYERS];

    // config
    logic [4:0]                        r_cfg_lcnt;
    logic                              r_cfg_ds;
    logic [3:0]                        r_cfg_align;
    logic [nlws_pkg::ACC_CAP_W-1:0]    r_cfg_cap;
    logic                              r_cfg_fbuf;
    logic [7:0]                        r_cfg_olen;

    // walk state
    logic [LC-1:0]                     r_layer;
    logic [PW-1:0]                     r_unit;
    logic [nlws_pkg::BUD_W-1:0]        r_budget;

    // scan pipeline
    logic                              r_sc_v;
    logic [QW-1:0]                     r_sc_owoc;
    logic [KW-1:0]                     r_sc_rows;
    logic [BW-1:0]                     r_max;

    // live region intermediates
    logic [QW-1:0]                     r_owoc;
    logic [QW-1:0]                     r_ihiw;
    logic [QW-1:0]                     r_iwic;
    logic [PW-1:0]                     r_q1;
    logic [DW-1:0]                     r_row;
    logic [PW-1:0]                     r_convrows;
    logic [PW-1:0]                     r_inb;
    logic [PW-1:0]                     r_outis;
    logic [PW-1:0]                     r_dead;
    logic [BW-1:0]                     r_band;

    nlws_pkg::t_res                    r_res;

    logic [LC-1:0]                     cnt;
    logic                              fin;
    logic [LI-1:0]                     rd_addr;
    nlws_pkg::t_desc                   d;
    nlws_pkg::t_desc                   wr_desc;
    logic                              dense;
    logic [BW-1:0]                     sc_band;
    logic                              div_go;
    logic [PW-1:0]                     div_dividend;
    logic [QW-1:0]                     div_divisor;
    logic                              div_busy;
    logic [PW-1:0]                     div_q;
    logic [PW-1:0]                     units;
    logic [PW-1:0]                     diff;
    logic [nlws_pkg::BUD_W-1:0]        take;
    logic [PW:0]                       sum;
    logic [PW+KW-1:0]                  row_raw;
    logic [DW-1:0]                     row_cap;
    logic [PW-1:0]                     outrows;
    logic [PW-1:0]                     mask;
    logic [PW-1:0]                     off;

    function automatic logic [nlws_pkg::ACC_CAP_W-1:0] ACC_CAP_W_EXT(input logic [BW-1:0] v);
        return nlws_pkg::ACC_CAP_W'(v);
    endfunction

    assign cnt = (r_cfg_lcnt > 5'(nlws_pkg::MAX_LAYERS)) ? LC'(nlws_pkg::MAX_LAYERS)
                                                       : LC'(r_cfg_lcnt);
    assign fin     = (r_layer >= cnt);
    assign rd_addr = i_cmd.scan_en ? i_cmd.scan_idx : r_layer[LI-1:0];
    assign d       = r_tbl[rd_addr];
    assign dense   = (d.kind == nlws_pkg::KIND_DENSE);
    assign sc_band = BW'(r_sc_rows) * BW'(r_sc_owoc);

    always_comb begin
        wr_desc = i_desc;
        if (i_desc.kind == nlws_pkg::KIND_RSVD) begin
            wr_desc.kind = nlws_pkg::KIND_DENSE;
        end
    end

    // table writes
    always_ff @(posedge i_clk) begin
        if (i_cmd.take && (i_opcode == nlws_pkg::OP_LOAD)) begin
            r_tbl[i_slot] <= wr_desc;
        end
    end

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_lcnt  <= 5'd1;
            r_cfg_ds    <= 1'b0;
            r_cfg_align <= 4'd0;
            r_cfg_cap   <= nlws_pkg::ACC_CAP_W'(4096);
            r_cfg_fbuf  <= 1'b0;
            r_cfg_olen  <= 8'd10;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                nlws_pkg::CFG_LAYER_COUNT:   r_cfg_lcnt  <= i_cfg_data[4:0];
                nlws_pkg::CFG_DATAFLOW_MODE: r_cfg_ds    <= i_cfg_data[0];
                nlws_pkg::CFG_ALIGN_LOG2:    r_cfg_align <= i_cfg_data[3:0];
                nlws_pkg::CFG_ACC_CAPACITY:  r_cfg_cap   <= i_cfg_data;
                nlws_pkg::CFG_FINAL_BUFFER:  r_cfg_fbuf  <= i_cfg_data[0];
                nlws_pkg::CFG_OUTPUT_LENGTH: r_cfg_olen  <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    // divider shared by both quotients
    assign div_go       = i_cmd.div1_go || i_cmd.div2_go;
    assign div_dividend = i_cmd.div2_go ? r_q1 : r_unit;
    assign div_divisor  = i_cmd.div2_go ? QW'(d.k) : (r_cfg_ds ? r_owoc : QW'(d.iw));

    nlws_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_go),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_busy     (div_busy),
        .o_quot     (div_q)
    );

    // chunk arithmetic
    always_comb begin
        if (dense) begin
            units = PW'(d.oc);
        end else if (r_cfg_ds) begin
            units = PW'(r_owoc) * PW'(d.oh);
        end else begin
            units = PW'(r_ihiw);
        end
        diff = units - r_unit;
        take = '0;
        if (r_unit < units) begin
            take = (diff > PW'(r_budget)) ? r_budget : diff[nlws_pkg::BUD_W-1:0];
        end
        sum = (PW+1)'(r_unit) + (PW+1)'(take);
    end

    // row and output-row arithmetic
    always_comb begin
        if (r_cfg_ds && (d.kind == nlws_pkg::KIND_POOL)) begin
            row_raw = (PW+KW)'(div_q) * (PW+KW)'(d.k);
        end else begin
            row_raw = (PW+KW)'(div_q);
        end
        row_cap = (row_raw > (PW+KW)'(d.ih)) ? d.ih : row_raw[DW-1:0];
        outrows = (d.kind == nlws_pkg::KIND_POOL) ? div_q : r_convrows;
        mask    = {PW{1'b1}} << r_cfg_align;
        off     = r_dead & mask;
    end

    // walk state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_layer <= LC'(1);
            r_unit  <= '0;
        end else if (i_cmd.take && (i_opcode == nlws_pkg::OP_ABANDON)) begin
            r_layer <= cnt;
            r_unit  <= '0;
        end else if (i_cmd.begin_apply && !(ACC_CAP_W_EXT(r_max) > r_cfg_cap)) begin
            r_layer <= '0;
            r_unit  <= '0;
        end else if (i_cmd.chunk) begin
            if (sum >= (PW+1)'(units)) begin
                r_layer <= r_layer + LC'(1);
                r_unit  <= '0;
            end else begin
                r_unit  <= sum[PW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_budget <= (i_budget == '0) ? nlws_pkg::BUD_W'(1) : i_budget;
        end else if (i_cmd.chunk) begin
            r_budget <= r_budget - take;
        end
    end

    // begin scan: widest band
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sc_v <= 1'b0;
        end else begin
            r_sc_v <= i_cmd.scan_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_en) begin
            r_sc_owoc <= QW'(d.ow) * QW'(d.oc);
            r_sc_rows <= nlws_pkg::band_rows(d.kind, r_cfg_ds, d.k);
        end
        if (i_cmd.take) begin
            r_max <= '0;
        end else if (r_sc_v && (sc_band > r_max)) begin
            r_max <= sc_band;
        end
    end

    // live region pipeline
    always_ff @(posedge i_clk) begin
        if (i_cmd.prod) begin
            r_owoc <= QW'(d.ow) * QW'(d.oc);
            r_ihiw <= QW'(d.ih) * QW'(d.iw);
            r_iwic <= QW'(d.iw) * QW'(d.ic);
        end
        if (i_cmd.row) begin
            r_q1       <= div_q;
            r_row      <= row_cap;
            r_convrows <= (div_q >= PW'(d.k)) ? (div_q - PW'(d.k) + PW'(1)) : '0;
            r_inb      <= dense ? PW'(d.ic) : (PW'(r_ihiw) * PW'(d.ic));
        end
        if (i_cmd.fin1) begin
            r_outis <= outrows * PW'(r_owoc);
            r_dead  <= dense ? '0 : (PW'(r_row) * PW'(r_iwic));
            r_band  <= BW'(nlws_pkg::band_rows(d.kind, r_cfg_ds, d.k)) * BW'(r_owoc);
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_res.status <= 1'b0;
        end else if (i_cmd.begin_apply) begin
            r_res.status <= (ACC_CAP_W_EXT(r_max) > r_cfg_cap);
        end
        if (i_cmd.hdr_status) begin
            r_res.first_unit <= r_unit;
            r_res.unit_count <= '0;
            if (fin) begin
                r_res.layer_index <= '0;
                r_res.kernel_kind <= nlws_pkg::KIND_CONV;
                r_res.buffer_sel  <= {1'b0, r_cfg_fbuf};
            end else begin
                r_res.layer_index <= r_layer[LI-1:0];
                r_res.kernel_kind <= d.kind;
                r_res.buffer_sel  <= d.bufs;
            end
        end else if (i_cmd.chunk) begin
            r_res.layer_index <= r_layer[LI-1:0];
            r_res.kernel_kind <= d.kind;
            r_res.first_unit  <= r_unit;
            r_res.unit_count  <= PW'(take);
            r_res.buffer_sel  <= d.bufs;
        end
        if (i_cmd.fin2) begin
            r_res.finished <= fin;
            if (fin) begin
                r_res.live_in_offset  <= '0;
                r_res.live_in_length  <= PW'(r_cfg_olen);
                r_res.live_out_length <= '0;
                r_res.live_acc_bytes  <= '0;
            end else begin
                r_res.live_in_offset  <= off;
                r_res.live_in_length  <= r_inb - off;
                r_res.live_out_length <= (r_cfg_ds || dense) ? r_unit : r_outis;
                r_res.live_acc_bytes  <= (r_unit != '0) ? PW'({r_band, 2'b00}) : '0;
            end
        end
    end

    assign o_res             = r_res;
    assign o_sts.fin         = fin;
    assign o_sts.budget_zero = (r_budget == '0);
    assign o_sts.div_busy    = div_busy;
    assign o_sts.cnt         = cnt;
endmodule

@@ hw/rtl/nlws_ctrl.sv @@
// Controller state machine: sequences scan, chunk and live-region steps.
// Depends on nlws_pkg.
module nlws_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  logic [1:0]                i_in_op,
    output logic                      o_in_ready,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic                      o_out_last,
    input  nlws_pkg::t_dp_sts         i_sts,
    output nlws_pkg::t_ctl_cmd        o_cmd
);
    typedef enum logic [14:0] {
        S_IDLE   = 15'b000000000000001,
        S_SCAN   = 15'b000000000000010,
        S_DRAIN  = 15'b000000000000100,
        S_DECIDE = 15'b000000000001000,
        S_CPROD  = 15'b000000000010000,
        S_CHUNK  = 15'b000000000100000,
        S_LPROD  = 15'b000000001000000,
        S_D1GO   = 15'b000000010000000,
        S_D1WAIT = 15'b000000100000000,
        S_ROW    = 15'b000001000000000,
        S_D2GO   = 15'b000010000000000,
        S_D2WAIT = 15'b000100000000000,
        S_FIN1   = 15'b001000000000000,
        S_FIN2   = 15'b010000000000000,
        S_OUT    = 15'b100000000000000
    } t_state;

    localparam int LI = nlws_pkg::LIDX_W;
    localparam int LC = nlws_pkg::LCNT_W;

    t_state           r_state, n_state;
    logic [LI-1:0]    r_idx, n_idx;
    logic             r_chunkmode, n_chunkmode;
    logic             take;
    logic             more;

    assign take = (r_state == S_IDLE) && i_in_valid;
    assign more = r_chunkmode && !i_sts.fin && !i_sts.budget_zero;

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_chunkmode = r_chunkmode;
        o_cmd       = '0;
        o_cmd.take  = take;
        o_cmd.scan_idx = r_idx;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_chunkmode = 1'b0;
                    n_idx       = '0;
                    case (i_in_op)
                        nlws_pkg::OP_BEGIN: begin
                            n_state = (i_sts.cnt == '0) ? S_DRAIN : S_SCAN;
                        end
                        nlws_pkg::OP_STEP: begin
                            if (i_sts.fin) begin
                                n_state = S_LPROD;
                            end else begin
                                n_state     = S_CPROD;
                                n_chunkmode = 1'b1;
                            end
                        end
                        default: begin
                            n_state = S_LPROD;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                o_cmd.scan_en = 1'b1;
                if ((LC'(r_idx) + LC'(1)) == i_sts.cnt) begin
                    n_state = S_DRAIN;
                end else begin
                    n_idx = r_idx + LI'(1);
                end
            end
            S_DRAIN: begin
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                o_cmd.begin_apply = 1'b1;
                n_state = S_LPROD;
            end
            S_CPROD: begin
                o_cmd.prod = 1'b1;
                n_state = S_CHUNK;
            end
            S_CHUNK: begin
                o_cmd.chunk = 1'b1;
                n_state = S_LPROD;
            end
            S_LPROD: begin
                o_cmd.prod       = 1'b1;
                o_cmd.hdr_status = !r_chunkmode;
                n_state = S_D1GO;
            end
            S_D1GO: begin
                o_cmd.div1_go = 1'b1;
                n_state = S_D1WAIT;
            end
            S_D1WAIT: begin
                if (!i_sts.div_busy) begin
                    n_state = S_ROW;
                end
            end
            S_ROW: begin
                o_cmd.row = 1'b1;
                n_state = S_D2GO;
            end
            S_D2GO: begin
                o_cmd.div2_go = 1'b1;
                n_state = S_D2WAIT;
            end
            S_D2WAIT: begin
                if (!i_sts.div_busy) begin
                    n_state = S_FIN1;
                end
            end
            S_FIN1: begin
                o_cmd.fin1 = 1'b1;
                n_state = S_FIN2;
            end
            S_FIN2: begin
                o_cmd.fin2 = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_out_ready) begin
                    n_state = more ? S_CPROD : S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_chunkmode <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_chunkmode <= n_chunkmode;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign o_out_last  = !more;
endmodule

@@ hw/rtl/nn_layer_walk_sequencer_top.sv @@
// Top level of the layer walk sequencer: controller plus datapath.
// Depends on nlws_pkg, nlws_cmd_if, nlws_res_if, nlws_ctrl, nlws_datapath.
//
// Usage:
//  - i_cmd carries one command per transaction: load a descriptor, begin a walk,
//    step with a unit budget, or abandon. o_res returns result transactions;
//    o_res.last marks the final result of a command.
//  - Config is written through i_cfg_we/i_cfg_idx/i_cfg_data while idle.
//  - One command at a time: i_cmd.ready is high only when no command is open.
//  - A load, an abandon or a step on a finished walk shows its result after
//    two passes of the shared bit-serial divider (unit over row size, then
//    rows over window), with setup, multiply and result stages around them.
//    A pass with a zero divisor ends at once. A begin first runs the band
//    scan over the loaded layers. Each chunk of a step adds a product and a
//    chunk stage before the same sequence.
//  - i_cmd.ready returns the cycle after the last result is taken.
//  - When o_res stalls, the result holds in its output register and the block
//    waits; nothing is dropped.
//  - Reset (i_rst_n low, synchronous) sets config to defaults and the walk to
//    finished. The descriptor table is not cleared; load entries before use.
module nn_layer_walk_sequencer_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    nlws_cmd_if.sink                          i_cmd,
    nlws_res_if.source                        o_res,
    input  logic                              i_cfg_we,
    input  logic [nlws_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [nlws_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    nlws_pkg::t_ctl_cmd   cmd;
    nlws_pkg::t_dp_sts    sts;
    nlws_pkg::t_res       res;
    nlws_pkg::t_desc      desc;

    // descriptor fields straight off the command channel
    assign desc.kind = i_cmd.layer_kind;
    assign desc.ih   = i_cmd.in_height;
    assign desc.iw   = i_cmd.in_width;
    assign desc.ic   = i_cmd.in_channels;
    assign desc.oh   = i_cmd.out_height;
    assign desc.ow   = i_cmd.out_width;
    assign desc.oc   = i_cmd.out_channels;
    assign desc.k    = i_cmd.window_size;
    assign desc.bufs = i_cmd.buffer_pair;

    nlws_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_cmd.valid),
        .i_in_op     (i_cmd.opcode),
        .o_in_ready  (i_cmd.ready),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .o_out_last  (o_res.last),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    nlws_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_opcode   (i_cmd.opcode),
        .i_desc     (desc),
        .i_slot     (i_cmd.layer_slot),
        .i_budget   (i_cmd.unit_budget),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_res      (res)
    );

    // result payload is held in the datapath output register
    assign o_res.layer_index     = res.layer_index;
    assign o_res.kernel_kind     = res.kernel_kind;
    assign o_res.first_unit      = res.first_unit;
    assign o_res.unit_count      = res.unit_count;
    assign o_res.buffer_sel      = res.buffer_sel;
    assign o_res.finished        = res.finished;
    assign o_res.live_in_offset  = res.live_in_offset;
    assign o_res.live_in_length  = res.live_in_length;
    assign o_res.live_out_length = res.live_out_length;
    assign o_res.live_acc_bytes  = res.live_acc_bytes;
    assign o_res.status          = res.status;
endmodule

@@ hw/rtl/nlws_chk.sv @@
// Port-level checker for the layer walk sequencer, bound to the top level.
// Depends on nn_layer_walk_sequencer_top_assert.svh.
`include "nn_layer_walk_sequencer_top_assert.svh"

module nlws_chk (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_out_last
);
    `NLWS_CHK_NEXT(a_last_hold, i_out_valid && !i_out_ready, $stable(i_out_last), "last moved")
    `NLWS_CHK_NEXT(a_out_stays, i_out_valid && !i_out_ready, i_out_valid, "result dropped")
    `NLWS_CHK_IMPL(a_one_open, i_out_valid, !i_in_ready, "command taken with result open")
    `NLWS_CHK_NEXT(a_busy_after_take, i_in_valid && i_in_ready, !i_in_ready, "ready after take")
    `NLWS_CHK_NEXT(a_last_ends, i_out_valid && i_out_ready && i_out_last, !i_out_valid,
                   "result after last")
endmodule

bind nn_layer_walk_sequencer_top nlws_chk u_nlws_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_cmd.valid),
    .i_in_ready  (i_cmd.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_last  (o_res.last)
);
